@@ hw/rtl/b64cs_pkg.sv @@
// Shared types, constants and alphabet functions for the base64 stream codec.
// No dependencies; the front end, queue, back end and top level import this package.
package b64cs_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam logic [7:0] PAD_CHAR = 8'd61;

    typedef enum logic
    {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    // Result of a character lookup: hit for alphabet or pad, pad for '='.
    typedef struct packed
    {
        logic       hit;
        logic       pad;
        logic [5:0] val;
    } sym_t;

    // One unit of back-end work: up to four result bytes, issued in order.
    typedef struct packed
    {
        logic [3:0][7:0] bytes;
        logic [1:0]      count_m1;
        logic            last;
        logic            bare;
    } job_t;

    function automatic logic [7:0] sym_to_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)
            return w + 8'd65;
        else if (v < 6'd52)
            return w + 8'd71;
        else if (v < 6'd62)
            return w - 8'd4;
        else if (v == 6'd62)
            return 8'd43;
        else
            return 8'd47;
    endfunction

    function automatic sym_t char_to_sym(input logic [7:0] c);
        sym_t s;
        logic [7:0] t;
        s = '{hit: 1'b0, pad: 1'b0, val: 6'd0};
        t = 8'd0;
        if (c inside {[8'd65:8'd90]})
        begin
            t = c - 8'd65;
            s.hit = 1'b1;
        end
        else if (c inside {[8'd97:8'd122]})
        begin
            t = c - 8'd71;
            s.hit = 1'b1;
        end
        else if (c inside {[8'd48:8'd57]})
        begin
            t = c + 8'd4;
            s.hit = 1'b1;
        end
        else if (c == 8'd43)
        begin
            t = 8'd62;
            s.hit = 1'b1;
        end
        else if (c == 8'd47)
        begin
            t = 8'd63;
            s.hit = 1'b1;
        end
        else if (c == PAD_CHAR)
        begin
            s.hit = 1'b1;
            s.pad = 1'b1;
        end
        s.val = t[5:0];
        return s;
    endfunction

endpackage

@@ hw/rtl/b64cs_if.sv @@
// Valid/ready channel interfaces for codec input items and result items.
// Depends on nothing.
interface b64cs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_in;

    modport source (output valid, output in_byte, output last_in, input ready);
    modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

interface b64cs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;

    modport source (output valid, output out_byte, output byte_valid, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input out_last,
                    output ready);
endinterface

@@ hw/rtl/b64cs_front.sv @@
// Front end: holds mode and group state, classifies each input item and
// builds a job for the back end. Depends on b64cs_pkg.
module b64cs_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    input  logic              last_in,
    output logic              push,
    output b64cs_pkg::job_t   push_job
);
    import b64cs_pkg::*;

    mode_t       mode_reg;
    logic [23:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [1:0]  pad_reg, pad_next;

    logic [23:0] acc_enc, acc_dec, part;
    logic [1:0]  pad_upd;
    sym_t        sym;
    logic        job_ok;
    job_t        job;

    always_comb
    begin
        acc_enc  = {acc_reg[15:0], in_byte};
        sym      = char_to_sym(in_byte);
        acc_dec  = {acc_reg[17:0], sym.val};
        pad_upd  = pad_reg | {sym.pad && (cnt_reg == 2'd3), sym.pad && (cnt_reg == 2'd2)};
        part     = (cnt_reg == 2'd0) ? {acc_enc[7:0], 16'h0} : {acc_enc[15:0], 8'h0};

        acc_next = acc_reg;
        cnt_next = cnt_reg;
        pad_next = pad_reg;
        job_ok   = 1'b0;
        job      = '{bytes: '0, count_m1: 2'd0, last: 1'b0, bare: 1'b0};

        if (mode_reg == MODE_ENCODE)
        begin
            if (cnt_reg[1])
            begin
                // full group: four characters
                job_ok   = 1'b1;
                job.bytes[0] = sym_to_char(acc_enc[23:18]);
                job.bytes[1] = sym_to_char(acc_enc[17:12]);
                job.bytes[2] = sym_to_char(acc_enc[11:6]);
                job.bytes[3] = sym_to_char(acc_enc[5:0]);
                job.count_m1 = 2'd3;
                job.last     = last_in;
                acc_next = '0;
                cnt_next = 2'd0;
                pad_next = 2'd0;
            end
            else if (last_in)
            begin
                // partial group: data characters, then pad
                job_ok   = 1'b1;
                job.bytes[0] = sym_to_char(part[23:18]);
                job.bytes[1] = sym_to_char(part[17:12]);
                job.bytes[2] = (cnt_reg == 2'd1) ? sym_to_char(part[11:6]) : PAD_CHAR;
                job.bytes[3] = PAD_CHAR;
                job.count_m1 = 2'd3;
                job.last     = 1'b1;
                acc_next = '0;
                cnt_next = 2'd0;
                pad_next = 2'd0;
            end
            else
            begin
                acc_next = acc_enc;
                cnt_next = cnt_reg + 2'd1;
            end
        end
        else
        begin
            if (sym.hit && (cnt_reg == 2'd3))
            begin
                job_ok   = 1'b1;
                job.bytes[0] = acc_dec[23:16];
                job.bytes[1] = acc_dec[15:8];
                job.bytes[2] = acc_dec[7:0];
                job.count_m1 = pad_upd[0] ? 2'd0 : (pad_upd[1] ? 2'd1 : 2'd2);
                job.last     = last_in;
                acc_next = '0;
                cnt_next = 2'd0;
                pad_next = 2'd0;
            end
            else
            begin
                if (sym.hit)
                begin
                    acc_next = acc_dec;
                    cnt_next = cnt_reg + 2'd1;
                    pad_next = pad_upd;
                end
                if (last_in)
                begin
                    // drop the incomplete group and send a bare end marker
                    job_ok   = 1'b1;
                    job.last = 1'b1;
                    job.bare = 1'b1;
                    acc_next = '0;
                    cnt_next = 2'd0;
                    pad_next = 2'd0;
                end
            end
        end

        push     = accept && job_ok;
        push_job = job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ENCODE;
            acc_reg  <= '0;
            cnt_reg  <= 2'd0;
            pad_reg  <= 2'd0;
        end
        else if (cfg_we)
        begin
            mode_reg <= mode_t'(cfg_wdata);
            acc_reg  <= '0;
            cnt_reg  <= 2'd0;
            pad_reg  <= 2'd0;
        end
        else if (accept)
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            pad_reg <= pad_next;
        end
    end

endmodule

@@ hw/rtl/b64cs_queue.sv @@
// Small job queue between front and back end, register based.
// Depends on b64cs_pkg.
module b64cs_queue
#(
    parameter int DEPTH = b64cs_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  b64cs_pkg::job_t push_job,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output b64cs_pkg::job_t head
);
    import b64cs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          slots [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == FULL_CNT);
    assign empty = (cnt_reg == '0);
    assign head  = slots[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == LAST_PTR) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == LAST_PTR) ? '0 : rd_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ hw/rtl/b64cs_back.sv @@
// Back end: walks the job at the queue head one result per transfer.
// Depends on b64cs_pkg.
module b64cs_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            empty,
    input  b64cs_pkg::job_t head,
    output logic            pop,
    output logic            valid,
    input  logic            ready,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            out_last
);
    import b64cs_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       at_end, xfer;

    always_comb
    begin
        valid      = !empty;
        at_end     = (idx_reg == head.count_m1);
        out_byte   = head.bytes[idx_reg];
        byte_valid = !head.bare;
        out_last   = head.last && at_end;
        xfer       = valid && ready;
        pop        = xfer && at_end;
        idx_next   = idx_reg;
        if (xfer)
            idx_next = at_end ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

endmodule

@@ hw/rtl/base64_codec_stream_unit.sv @@
// Top level of the streaming base64 codec (standard alphabet, '=' padding).
// Depends on b64cs_pkg, b64cs_if, b64cs_front, b64cs_queue and b64cs_back.

// Streaming base64 codec. Write cfg_wdata with cfg_we while the block is idle:
// 0 selects encode, 1 selects decode; every write also clears the partial
// group. Input items transfer on "item", results on "result". The front end
// takes one input item per cycle whenever the job queue has room, including
// items that produce nothing. An item that completes a group (or ends a
// message) queues a job of one to four results, and the back end sends one
// result per cycle while result.ready is high. In encode, four characters per
// three bytes, the output port sets the sustained rate; in decode, at most
// three bytes per four characters, the input does. The queue of QUEUE_DEPTH
// jobs lets the input keep flowing while results wait to be taken. A job is
// registered in the queue before its first result is offered. In decode,
// characters outside the alphabet are dropped, an incomplete trailing group
// is discarded and an end marker with byte_valid low closes the message.
module base64_codec_stream_unit
#(
    parameter int QUEUE_DEPTH = b64cs_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_we,
    input  logic  cfg_wdata,
    b64cs_in_if.sink    item,
    b64cs_out_if.source result
);
    import b64cs_pkg::*;

    logic accept;
    logic push, pop, full, empty;
    job_t push_job, head;

    // Take an item whenever the queue can hold a job it might produce.
    assign item.ready = !full;
    assign accept     = item.valid && item.ready;

    // Classify the transfer and update group state.
    b64cs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .in_byte   (item.in_byte),
        .last_in   (item.last_in),
        .push      (push),
        .push_job  (push_job)
    );

    // Hold pending jobs so each side may stall on its own.
    b64cs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    // Drain the head job one result per transfer; drop it after the final one.
    b64cs_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .head       (head),
        .pop        (pop),
        .valid      (result.valid),
        .ready      (result.ready),
        .out_byte   (result.out_byte),
        .byte_valid (result.byte_valid),
        .out_last   (result.out_last)
    );

endmodule
